@@ src/vimsch_pkg.sv @@
// ----------------------------------------------------------------------------
// vimsch_pkg: shared types and constants of the VOQ match scheduler
// Controller states, command and status bundles, field layout constants.
// ----------------------------------------------------------------------------
package vimsch_pkg;

    localparam int FIELD_PORTS = 8;
    localparam int DEST_W      = 3;
    localparam int CNT_W       = 4;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 48;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ARRIVE,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic arrive;
        logic mem_rd;
        logic mem_wr;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic round_none;
        logic out_free;
    } status_t;

endpackage

@@ src/vimsch_ctrl.sv @@
// ----------------------------------------------------------------------------
// vimsch_ctrl: slot sequencer of the VOQ match scheduler
// Steps one slot through load, match rounds, arrivals and queue updates.
// ----------------------------------------------------------------------------
module vimsch_ctrl #(
    parameter int NUM_PORTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  vimsch_pkg::status_t             status,
    output vimsch_pkg::cmd_t                cmd,
    output logic [$clog2(2*NUM_PORTS)-1:0]  op_idx
);

    localparam int OW = $clog2(2*NUM_PORTS);
    localparam logic [OW-1:0] OP_LAST = OW'(2*NUM_PORTS-1);

    vimsch_pkg::state_t state_reg, state_next;
    logic [OW-1:0]      op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vimsch_pkg::ST_IDLE;
            op_reg    <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            vimsch_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = vimsch_pkg::ST_MATCH;
                end
            end
            vimsch_pkg::ST_MATCH: begin
                cmd.round = 1'b1;
                if (status.round_none) begin
                    state_next = vimsch_pkg::ST_ARRIVE;
                end
            end
            vimsch_pkg::ST_ARRIVE: begin
                cmd.arrive = 1'b1;
                op_next    = '0;
                state_next = vimsch_pkg::ST_READ;
            end
            vimsch_pkg::ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = vimsch_pkg::ST_WRITE;
            end
            vimsch_pkg::ST_WRITE: begin
                cmd.mem_wr = 1'b1;
                if (op_reg == OP_LAST) begin
                    state_next = vimsch_pkg::ST_DONE;
                end else begin
                    op_next    = op_reg + OW'(1);
                    state_next = vimsch_pkg::ST_READ;
                end
            end
            vimsch_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = vimsch_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vimsch_pkg::ST_IDLE;
            end
        endcase
    end

    assign op_idx = op_reg;

endmodule

@@ src/vimsch_datapath.sv @@
// ----------------------------------------------------------------------------
// vimsch_datapath: queue state, matcher and result register
// Holds queue counts, input totals and output buffer flags; runs one
// grant/accept round per command and reads, then writes, each queue entry.
// ----------------------------------------------------------------------------
module vimsch_datapath #(
    parameter int NUM_PORTS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  vimsch_pkg::cmd_t                     cmd,
    input  logic [$clog2(2*NUM_PORTS)-1:0]       op_idx,
    input  logic [vimsch_pkg::IN_W-1:0]          s_tdata,
    input  logic                                 cfg_wen,
    input  logic [vimsch_pkg::CNT_W-1:0]         cfg_wdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [vimsch_pkg::OUT_W-1:0]         m_tdata,
    output vimsch_pkg::status_t                  status
);

    localparam int N  = NUM_PORTS;
    localparam int PW = $clog2(N);
    localparam int OW = $clog2(2*N);
    localparam int AW = $clog2(N*N);
    localparam int FP = vimsch_pkg::FIELD_PORTS;
    localparam int DW = vimsch_pkg::DEST_W;
    localparam int CW = vimsch_pkg::CNT_W;
    localparam logic [AW-1:0] N_A = AW'(N);

    logic [CW-1:0]  limit_reg;
    logic [CW-1:0]  used_reg [N];
    logic [N*N-1:0] ne_reg;
    logic [N-1:0]   in_m_reg, out_m_reg, av_reg, arr_ok_reg;
    logic [PW-1:0]  match_reg [N];
    logic [PW-1:0]  dest_reg  [N];
    logic [FP-1:0]  tx_reg, drop_reg;
    logic [CW-1:0]  rd_reg;
    logic [CW-1:0]  mem [N*N];
    logic           m_valid_reg;
    logic [vimsch_pkg::OUT_W-1:0] m_data_reg;

    // arrival decode and transmit capture
    logic [N-1:0]   ld_av;
    logic [PW-1:0]  ld_dest [N];
    logic [FP-1:0]  ld_tx;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_ld
            if (g < FP) begin : g_field
                logic [DW-1:0] d;
                assign d          = s_tdata[FP + DW*g +: DW];
                assign ld_av[g]   = s_tdata[g] && (32'(d) < N);
                assign ld_dest[g] = PW'(d);
            end else begin : g_none
                assign ld_av[g]   = 1'b0;
                assign ld_dest[g] = '0;
            end
        end
        for (g = 0; g < FP; g++) begin : g_tx
            if (g < N) begin : g_on
                assign ld_tx[g] = out_m_reg[g];
            end else begin : g_off
                assign ld_tx[g] = 1'b0;
            end
        end
    endgenerate

    // one grant/accept round
    logic [N-1:0]  col  [N];
    logic [N-1:0]  gnt  [N];
    logic [N-1:0]  gin  [N];
    logic [N-1:0]  acc  [N];
    logic [PW-1:0] acc_idx [N];
    logic [N-1:0]  acc_in, acc_out;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            for (int i = 0; i < N; i++) begin
                col[j][i] = ne_reg[i*N + j] & ~in_m_reg[i] & ~out_m_reg[j];
            end
            gnt[j] = col[j] & (~col[j] + N'(1));
        end
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                gin[i][j] = gnt[j][i];
            end
            acc[i] = gin[i] & (~gin[i] + N'(1));
        end
        acc_out = '0;
        for (int i = 0; i < N; i++) begin
            acc_in[i]  = |acc[i];
            acc_idx[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (acc[i][j]) begin
                    acc_idx[i] = acc_idx[i] | PW'(j);
                end
            end
            acc_out = acc_out | acc[i];
        end
    end

    // arrivals against the input totals
    logic [CW-1:0] used_dec [N];
    logic [CW-1:0] used_new [N];
    logic [N-1:0]  arr_ok, arr_drop;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            used_dec[i] = (in_m_reg[i] && used_reg[i] != '0) ? used_reg[i] - CW'(1)
                                                             : used_reg[i];
            used_new[i] = used_dec[i];
            arr_ok[i]   = 1'b0;
            arr_drop[i] = 1'b0;
            if (av_reg[i]) begin
                if (used_dec[i] >= limit_reg) begin
                    arr_drop[i] = 1'b1;
                end else begin
                    arr_ok[i]   = 1'b1;
                    used_new[i] = used_dec[i] + CW'(1);
                end
            end
        end
    end

    // queue entry update: even op decrements the matched queue, odd op enqueues
    logic [PW-1:0] op_i;
    logic          op_kind;
    logic [PW-1:0] j_sel;
    logic          en_sel;
    logic [AW-1:0] addr;
    logic [CW-1:0] cnt, cnt_new;

    always_comb begin
        op_i    = op_idx[OW-1:1];
        op_kind = op_idx[0];
        j_sel   = op_kind ? dest_reg[op_i] : match_reg[op_i];
        en_sel  = op_kind ? arr_ok_reg[op_i] : in_m_reg[op_i];
        addr    = AW'(AW'(op_i) * N_A + AW'(j_sel));
        cnt     = ne_reg[addr] ? rd_reg : '0;
        if (op_kind) begin
            cnt_new = (cnt < vimsch_pkg::CNT_MAX) ? cnt + CW'(1) : cnt;
        end else begin
            cnt_new = (cnt != '0) ? cnt - CW'(1) : cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_reg <= mem[addr];
        end
        if (cmd.mem_wr && en_sel) begin
            mem[addr] <= cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tx_reg <= ld_tx;
            for (int i = 0; i < N; i++) begin
                dest_reg[i] <= ld_dest[i];
            end
        end
        if (cmd.round) begin
            for (int i = 0; i < N; i++) begin
                if (acc_in[i]) begin
                    match_reg[i] <= acc_idx[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= vimsch_pkg::LIMIT_RESET;
            ne_reg     <= '0;
            in_m_reg   <= '0;
            out_m_reg  <= '0;
            av_reg     <= '0;
            arr_ok_reg <= '0;
            drop_reg   <= '0;
            for (int i = 0; i < N; i++) begin
                used_reg[i] <= '0;
            end
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                in_m_reg  <= '0;
                out_m_reg <= '0;
                av_reg    <= ld_av;
            end
            if (cmd.round) begin
                in_m_reg  <= in_m_reg | acc_in;
                out_m_reg <= out_m_reg | acc_out;
            end
            if (cmd.arrive) begin
                arr_ok_reg <= arr_ok;
                for (int i = 0; i < N; i++) begin
                    used_reg[i] <= used_new[i];
                end
                for (int i = 0; i < FP; i++) begin
                    drop_reg[i] <= (i < N) ? arr_drop[i % N] : 1'b0;
                end
            end
            if (cmd.mem_wr && en_sel) begin
                ne_reg[addr] <= (cnt_new != '0);
            end
        end
    end

    // result assembly and output register
    logic [FP-1:0]    res_mvalid;
    logic [FP*DW-1:0] res_mport;
    logic [FP-1:0]    arr_ok_f;

    generate
        for (g = 0; g < FP; g++) begin : g_res
            if (g < N) begin : g_on
                assign res_mvalid[g]           = in_m_reg[g];
                assign res_mport[DW*g +: DW]   = in_m_reg[g] ? DW'(match_reg[g]) : '0;
                assign arr_ok_f[g]             = arr_ok_reg[g];
            end else begin : g_off
                assign res_mvalid[g]           = 1'b0;
                assign res_mport[DW*g +: DW]   = '0;
                assign arr_ok_f[g]             = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_data_reg <= {drop_reg, res_mport, res_mvalid, tx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid          = m_valid_reg;
    assign m_tdata           = m_data_reg;
    assign status.round_none = ~|acc_in;
    assign status.out_free   = ~m_valid_reg | m_tready;

`ifndef SYNTHESIS
    a_match_one_to_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(in_m_reg) == $countones(out_m_reg))
        else $error("matched inputs and outputs differ in number");

    a_dec_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_wr && !op_kind && in_m_reg[op_i]) |-> ne_reg[addr])
        else $error("matched queue is empty at decrement");

    a_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.arrive |=> ((drop_reg & arr_ok_f) == '0))
        else $error("arrival both dropped and enqueued");
`endif

endmodule

@@ src/voq_iterative_match_scheduler.sv @@
// ----------------------------------------------------------------------------
// voq_iterative_match_scheduler: VOQ crossbar slot scheduler
// Each request on s_ is one switch time slot: arrivals per input. Each
// request on m_ reports that slot's transmits, matches and drops.
// Usage:
//   s_tdata carries the arrival mask and packed destinations of one slot;
//   m_tdata returns one result per slot, in order.
//   cfg_wen/cfg_wdata write the per-input buffer limit while idle.
// Sequence:
//   m_tvalid rises after the grant/accept rounds, the arrival step and the
//   queue count updates, once the output register is free. There are 1 to
//   NUM_PORTS+1 rounds, one per cycle, the last adding no match. Queue counts
//   sit in a single-port memory: a read and a write for each input's match
//   and each input's arrival. One slot is in work at a time; the next request
//   is accepted once the controller is back in idle after the result is loaded.
// Reset:
//   aresetn clears all queues, input totals and output buffers and sets
//   the limit to 4. Queue memory needs no clearing pass.
// Stall:
//   A held result stays on m_tdata; the next slot is accepted meanwhile and
//   waits at its end until the output register frees.
// ----------------------------------------------------------------------------
module voq_iterative_match_scheduler #(
    parameter int NUM_PORTS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] arrival_valid, [31:8] arrival_dest
    input  logic [vimsch_pkg::IN_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] transmit_valid, [15:8] match_valid, [39:16] match_port, [47:40] drop_mask
    output logic [vimsch_pkg::OUT_W-1:0]  m_tdata,
    input  logic                          cfg_wen,
    input  logic [vimsch_pkg::CNT_W-1:0]  cfg_wdata
);

    vimsch_pkg::cmd_t                   cmd;
    vimsch_pkg::status_t                status;
    logic [$clog2(2*NUM_PORTS)-1:0]     op_idx;

    vimsch_ctrl #(
        .NUM_PORTS (NUM_PORTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .op_idx   (op_idx)
    );

    vimsch_datapath #(
        .NUM_PORTS (NUM_PORTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .op_idx    (op_idx),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .status    (status)
    );

endmodule

@@ verif/vimsch_slot_checker.sv @@
// ----------------------------------------------------------------------------
// vimsch_slot_checker: slot result checker for the VOQ match scheduler
// Watches the slot request channel, the result channel and limit writes,
// predicts each slot's transmits, matches and drops from its own copy of the
// queue counts, and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module vimsch_slot_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [7:0] arrival_valid, [31:8] arrival_dest
    input  logic [vimsch_pkg::IN_W-1:0]   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] transmit_valid, [15:8] match_valid, [39:16] match_port, [47:40] drop_mask
    input  logic [vimsch_pkg::OUT_W-1:0]  m_tdata,
    input  logic                          cfg_wen,
    input  logic [vimsch_pkg::CNT_W-1:0]  cfg_wdata,
    output int                            error_count,
    output int                            slots_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NP = vimsch_pkg::FIELD_PORTS;

    typedef struct packed {
        logic [7:0]  drop_mask;
        logic [23:0] match_port;
        logic [7:0]  match_valid;
        logic [7:0]  transmit_valid;
    } slot_report_t;

    logic [vimsch_pkg::CNT_W-1:0] voq_depth [NP][NP];
    logic [vimsch_pkg::CNT_W-1:0] port_load [NP];
    logic [NP-1:0]                out_buf_full;
    logic [vimsch_pkg::CNT_W-1:0] buf_limit;
    slot_report_t                 expected_reports [$];
    int                           mismatches = 0;

    assign error_count = mismatches;

    function automatic slot_report_t schedule_slot(logic [7:0] arr_mask, logic [23:0] arr_dest);
        slot_report_t rep;
        logic [NP-1:0] in_taken;
        logic [NP-1:0] out_taken;
        int            paired [NP];
        int            grant [NP];
        int            accept [NP];
        bit            progress;
        int            d;
        rep = '0;
        rep.transmit_valid = out_buf_full;
        out_buf_full = '0;
        in_taken = '0;
        out_taken = '0;
        for (int i = 0; i < NP; i++) paired[i] = -1;
        progress = 1'b1;
        while (progress) begin
            progress = 1'b0;
            for (int j = 0; j < NP; j++) begin
                grant[j] = -1;
                accept[j] = -1;
            end
            for (int j = 0; j < NP; j++) begin
                if (!out_taken[j]) begin
                    for (int i = 0; i < NP; i++) begin
                        if (grant[j] < 0 && !in_taken[i] && voq_depth[i][j] != 0)
                            grant[j] = i;
                    end
                end
            end
            for (int j = 0; j < NP; j++) begin
                if (grant[j] >= 0 && accept[grant[j]] < 0) begin
                    accept[grant[j]] = j;
                    progress = 1'b1;
                end
            end
            for (int i = 0; i < NP; i++) begin
                if (accept[i] >= 0) begin
                    paired[i] = accept[i];
                    in_taken[i] = 1'b1;
                    out_taken[accept[i]] = 1'b1;
                end
            end
        end
        for (int i = 0; i < NP; i++) begin
            if (paired[i] >= 0) begin
                if (voq_depth[i][paired[i]] != 0) voq_depth[i][paired[i]]--;
                if (port_load[i] != 0) port_load[i]--;
                out_buf_full[paired[i]] = 1'b1;
                rep.match_valid[i] = 1'b1;
                rep.match_port[3*i +: 3] = 3'(paired[i]);
            end
        end
        for (int i = 0; i < NP; i++) begin
            if (arr_mask[i]) begin
                d = int'(arr_dest[3*i +: 3]);
                if (port_load[i] >= buf_limit) begin
                    rep.drop_mask[i] = 1'b1;
                end else begin
                    if (voq_depth[i][d] != vimsch_pkg::CNT_MAX) voq_depth[i][d]++;
                    port_load[i]++;
                end
            end
        end
        return rep;
    endfunction

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        slot_report_t got;
        slot_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) begin
                port_load[i] = '0;
                for (int j = 0; j < NP; j++) voq_depth[i][j] = '0;
            end
            out_buf_full = '0;
            buf_limit = vimsch_pkg::LIMIT_RESET;
            expected_reports.delete();
        end else begin
            if (cfg_wen) buf_limit = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = slot_report_t'(m_tdata);
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with no slot pending, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("transmit_valid", 24'(want.transmit_valid),
                                24'(got.transmit_valid));
                    check_field("match_valid", 24'(want.match_valid), 24'(got.match_valid));
                    check_field("match_port", want.match_port, got.match_port);
                    check_field("drop_mask", 24'(want.drop_mask), 24'(got.drop_mask));
                end
            end
            if (s_tvalid && s_tready)
                expected_reports.insert(expected_reports.size(),
                                        schedule_slot(s_tdata[7:0], s_tdata[31:8]));
        end
        slots_pending <= expected_reports.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the VOQ iterative match scheduler
// Drives slot requests and buffer limit writes with random gaps and result
// back-pressure, runs a directed set of corner slots followed by random
// traffic under several limits, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 60;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [vimsch_pkg::IN_W-1:0]      s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [vimsch_pkg::OUT_W-1:0]     m_tdata;
    logic                             cfg_wen = 1'b0;
    logic [vimsch_pkg::CNT_W-1:0]     cfg_wdata = '0;
    int                               error_count;
    int                               slots_pending;
    bit                               steady = 1'b0;
    int                               stall_left = 0;

    always #6 aclk = ~aclk;

    voq_iterative_match_scheduler #(.NUM_PORTS(8)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    vimsch_slot_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .slots_pending (slots_pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output port of input i is (base + step*i) mod 8
    function automatic logic [23:0] spread_dest(int base, int step);
        logic [23:0] d;
        for (int i = 0; i < vimsch_pkg::FIELD_PORTS; i++) d[3*i +: 3] = 3'(base + step * i);
        return d;
    endfunction

    // back-pressure on results
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_slot(logic [7:0] arr_mask, logic [23:0] arr_dest);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) >= 55) gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {arr_dest, arr_mask};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_slot();
        int          mode;
        logic [7:0]  arr_mask;
        logic [23:0] arr_dest;
        logic [2:0]  hot_a;
        logic [2:0]  hot_b;
        mode = $urandom_range(0, 99);
        arr_mask = 8'($urandom());
        arr_dest = 24'($urandom());
        if (mode < 20) begin
            // hold traffic on one or two outputs
            hot_a = 3'($urandom());
            hot_b = 3'($urandom());
            for (int i = 0; i < vimsch_pkg::FIELD_PORTS; i++)
                arr_dest[3*i +: 3] = $urandom_range(0, 1) ? hot_a : hot_b;
        end else if (mode < 35) begin
            arr_mask = 8'(1 << $urandom_range(0, 7));
        end else if (mode < 45) begin
            arr_mask = 8'hFF;
        end else if (mode < 60) begin
            arr_mask = 8'h00;
        end
        send_slot(arr_mask, arr_dest);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (slots_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [vimsch_pkg::CNT_W-1:0] value);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        logic [vimsch_pkg::CNT_W-1:0] phase_limit [NUM_PHASES];
        phase_limit[0] = 4'd15;
        phase_limit[1] = 4'd1;
        phase_limit[2] = 4'd0;
        phase_limit[3] = 4'd15;
        phase_limit[4] = 4'($urandom_range(2, 14));
        phase_limit[5] = 4'd3;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed slots at the reset limit
        send_slot(8'h00, 24'hFFFFFF);
        send_slot(8'hFF, spread_dest(0, 0));
        send_slot(8'hFF, spread_dest(7, 0));
        send_slot(8'hFF, spread_dest(0, 1));
        send_slot(8'hFF, spread_dest(7, 7));
        repeat (5) send_slot(8'hFF, spread_dest(3, 0));
        send_slot(8'h00, spread_dest(3, 0));
        send_slot(8'h01, spread_dest(5, 1));
        send_slot(8'h80, spread_dest(2, 3));
        send_slot(8'h55, 24'hFFFFFF);
        send_slot(8'hAA, 24'h000000);
        repeat (4) send_slot(8'h00, 24'($urandom()));
        wait_drained();

        // limit zero drops every arrival
        write_limit(4'd0);
        send_slot(8'hFF, spread_dest(0, 1));
        send_slot(8'hFF, 24'($urandom()));
        send_slot(8'h00, 24'($urandom()));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            steady = (p == 1 || p == 4);
            write_limit(phase_limit[p]);
            repeat (SLOTS_PER_PHASE) send_random_slot();
            wait_drained();
        end
        steady = 1'b0;

        if (error_count == 0 && slots_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #25ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ voq_iterative_match_scheduler.f @@
src/vimsch_pkg.sv
src/vimsch_ctrl.sv
src/vimsch_datapath.sv
src/voq_iterative_match_scheduler.sv
verif/vimsch_slot_checker.sv
verif/tb_top.sv
